### rtl/dnpt_pkg.sv
// ----------------------------------------------------------------------------
// dnpt_pkg
// Shared types and constants for the DNS NAT port table.
// ----------------------------------------------------------------------------
package dnpt_pkg;

  // table geometry (both powers of two)
  localparam int SETS  = 64;
  localparam int WAYS  = 4;
  localparam int NWAY  = SETS * WAYS;
  localparam int SET_W = $clog2(SETS);
  localparam int WAY_W = $clog2(WAYS);
  localparam int ADDR_W = SET_W + WAY_W;
  localparam int CNT_W  = ADDR_W + 1;

  localparam logic [11:0] MIN_QUERY_LEN = 12'd2;

  // stream widths
  localparam int IN_DATA_W  = 240;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 160;
  localparam int OUT_USER_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REDIRECT_IP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REDIRECT_PORT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARDER_ON  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXPIRY_MS     = 3'd4;

  typedef enum logic [1:0] {
    FN_REQUEST  = 2'd0,
    FN_RESPONSE = 2'd1,
    FN_FORWARD  = 2'd2,
    FN_TXLOOKUP = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_PASS     = 3'd0,
    ST_OK       = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_NOROOM   = 3'd3,
    ST_REJECTED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_WALK,
    FSM_DECIDE,
    FSM_SCAN,
    FSM_DONE
  } fsm_t;

  // one table entry
  typedef struct packed {
    logic [15:0] port;
    logic [15:0] txid;
    logic [31:0] server_ip;
    logic [15:0] server_port;
    logic [31:0] cli_addr;
    logic [31:0] if_index;
    logic [31:0] sub_if_index;
    logic [47:0] stamp;
  } row_t;

endpackage

### rtl/dns_nat_port_table_unit.sv
// ----------------------------------------------------------------------------
// dns_nat_port_table_unit
// Set-associative NAT table for redirected DNS traffic, keyed by client port.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_*    | slave     | tuser func, tdata item fields
//  out_*   | master    | tuser status, tdata result fields
//  cfg_*   | write     | register index and value
//
//  Request, response lookup and forward query walk the WAYS ways of one set
//  through the entry memory's single read port (accept, walk, decide,
//  hand-off to the output register). Transaction lookup walks all SETS*WAYS
//  entries. Disabled or rejected items go from accept straight to hand-off.
//  Reset clears the valid flip-flops at once; there is no clearing pass. One
//  item is in work at a time; a finished result waits in the output register
//  while the next item is taken.
// ----------------------------------------------------------------------------
module dns_nat_port_table_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // port, server_ip, server_port, cli_addr, if_index, sub_if_index,
  // txid, query_length, now_ms (from bit 0 up, zero pad to 240)
  input  logic [dnpt_pkg::IN_DATA_W-1:0]    in_tdata,
  // func
  input  logic [dnpt_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // addr_ip, addr_port, cli_addr_out, client_port_out, if_index_out,
  // sub_if_index_out (from bit 0 up)
  output logic [dnpt_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status
  output logic [dnpt_pkg::OUT_USER_W-1:0]   out_tuser,
  input  logic                              cfg_wr_en,
  input  logic [dnpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dnpt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dnpt_pkg::*;

  // configuration registers
  logic        enabled_r;
  logic [31:0] redirect_ip_r;
  logic [15:0] redirect_port_r;
  logic        forwarder_on_r;
  logic [31:0] expiry_ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r       <= 1'b0;
      redirect_ip_r   <= '0;
      redirect_port_r <= 16'd53;
      forwarder_on_r  <= 1'b0;
      expiry_ms_r     <= 32'd30000;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ENABLED:       enabled_r       <= cfg_wdata[0];
        REG_REDIRECT_IP:   redirect_ip_r   <= cfg_wdata;
        REG_REDIRECT_PORT: redirect_port_r <= cfg_wdata[15:0];
        REG_FORWARDER_ON:  forwarder_on_r  <= cfg_wdata[0];
        REG_EXPIRY_MS:     expiry_ms_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input field views
  logic [15:0] in_port;
  logic [11:0] in_qlen;
  assign in_port = in_tdata[15:0];
  assign in_qlen = in_tdata[187:176];

  // held item
  logic [IN_DATA_W-1:0] item_r;
  func_t                func_r;
  logic [15:0] it_port, it_sport, it_txid;
  logic [31:0] it_sip, it_cip, it_if, it_sub;
  logic [47:0] it_now;
  logic [SET_W-1:0] it_set;
  assign it_port  = item_r[15:0];
  assign it_sip   = item_r[47:16];
  assign it_sport = item_r[63:48];
  assign it_cip   = item_r[95:64];
  assign it_if    = item_r[127:96];
  assign it_sub   = item_r[159:128];
  assign it_txid  = item_r[175:160];
  assign it_now   = item_r[235:188];
  assign it_set   = it_port[SET_W-1:0];

  // entry memory and valid bits
  row_t              mem [NWAY];
  row_t              mem_q_r;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wr_addr;
  row_t              mem_wdata;
  logic [NWAY-1:0]   valid_r, valid_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wr_addr] <= mem_wdata;
    if (mem_rd_en) mem_q_r <= mem[mem_rd_addr];
  end

  // control and walk state
  fsm_t              state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] pend_idx_r, pend_idx_nxt;
  logic              hit_r, hit_nxt;
  logic [WAY_W-1:0]  hit_way_r, hit_way_nxt;
  row_t              hit_row_r, hit_row_nxt;
  logic              inv_r, inv_nxt;
  logic [WAY_W-1:0]  inv_way_r, inv_way_nxt;
  logic              exp_r, exp_nxt;
  logic [WAY_W-1:0]  exp_way_r, exp_way_nxt;
  logic [WAYS-1:0]   expv_r, expv_nxt;
  logic [47:0]       best_r, best_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [OUT_DATA_W-1:0] res_data_r, res_data_nxt;
  logic              out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  status_t           out_status_r;

  logic in_acc, walk_last, scan_last, load_out;
  logic pend_valid, pend_match, pend_exp;
  logic [47:0] pend_age;
  logic [WAY_W-1:0] pend_way;

  assign in_tready = (state_r == FSM_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign load_out  = (state_r == FSM_DONE) && (!out_tvalid_r || out_tready);

  // pending read evaluation
  assign pend_way   = pend_idx_r[WAY_W-1:0];
  assign pend_valid = valid_r[pend_idx_r];
  assign pend_match = pend_valid && (mem_q_r.port == it_port);
  assign pend_age   = it_now - mem_q_r.stamp;
  assign pend_exp   = pend_age > {16'd0, expiry_ms_r};
  assign walk_last  = pend_r && (pend_way == WAY_W'(WAYS - 1));
  assign scan_last  = pend_r && (pend_idx_r == ADDR_W'(NWAY - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_acc) begin
          priority if ((func_t'(in_tuser) == FN_REQUEST ||
                        func_t'(in_tuser) == FN_RESPONSE) && !enabled_r)
            state_nxt = FSM_DONE;
          else if (func_t'(in_tuser) == FN_FORWARD &&
                   (!forwarder_on_r || in_qlen < MIN_QUERY_LEN))
            state_nxt = FSM_DONE;
          else if (func_t'(in_tuser) == FN_TXLOOKUP)
            state_nxt = FSM_SCAN;
          else
            state_nxt = FSM_WALK;
        end
      end
      FSM_WALK:   if (walk_last) state_nxt = FSM_DECIDE;
      FSM_DECIDE: state_nxt = FSM_DONE;
      FSM_SCAN:   if (scan_last) state_nxt = FSM_DONE;
      FSM_DONE:   if (load_out) state_nxt = FSM_IDLE;
      default:    state_nxt = FSM_IDLE;
    endcase
  end

  // datapath and memory control
  logic             tgt_ok;
  logic [WAY_W-1:0] tgt_way;

  always_comb begin
    cnt_nxt        = cnt_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    hit_nxt        = hit_r;
    hit_way_nxt    = hit_way_r;
    hit_row_nxt    = hit_row_r;
    inv_nxt        = inv_r;
    inv_way_nxt    = inv_way_r;
    exp_nxt        = exp_r;
    exp_way_nxt    = exp_way_r;
    expv_nxt       = expv_r;
    best_nxt       = best_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    valid_nxt      = valid_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = '0;
    mem_we         = 1'b0;
    mem_wr_addr    = '0;
    mem_wdata      = hit_row_r;
    tgt_ok         = 1'b0;
    tgt_way        = '0;

    unique case (state_r)
      // take the item and settle the short cases
      FSM_IDLE: begin
        if (in_acc) begin
          cnt_nxt        = '0;
          hit_nxt        = 1'b0;
          inv_nxt        = 1'b0;
          exp_nxt        = 1'b0;
          best_nxt       = '0;
          res_data_nxt   = '0;
          res_status_nxt = ST_PASS;
          if (func_t'(in_tuser) == FN_FORWARD) res_status_nxt = ST_REJECTED;
        end
      end

      // read the ways of the set, one a cycle
      FSM_WALK: begin
        if (cnt_r < CNT_W'(WAYS)) begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = {it_set, cnt_r[WAY_W-1:0]};
          pend_nxt     = 1'b1;
          pend_idx_nxt = mem_rd_addr;
          cnt_nxt      = cnt_r + 1'b1;
        end
        if (pend_r) begin
          expv_nxt[pend_way] = pend_exp;
          if (pend_match && !hit_r) begin
            hit_nxt     = 1'b1;
            hit_way_nxt = pend_way;
            hit_row_nxt = mem_q_r;
          end
          if (!pend_valid && !inv_r) begin
            inv_nxt     = 1'b1;
            inv_way_nxt = pend_way;
          end
          if (pend_exp && !exp_r) begin
            exp_nxt     = 1'b1;
            exp_way_nxt = pend_way;
          end
        end
      end

      // allocate and write back, or return the matched entry
      FSM_DECIDE: begin
        res_data_nxt = '0;
        if (func_r == FN_RESPONSE) begin
          if (hit_r) begin
            res_status_nxt = ST_OK;
            res_data_nxt   = {hit_row_r.sub_if_index, hit_row_r.if_index,
                              it_port, hit_row_r.cli_addr,
                              hit_row_r.server_port, hit_row_r.server_ip};
          end else begin
            res_status_nxt = ST_NOTFOUND;
          end
        end else begin
          priority if (hit_r) begin
            tgt_ok = 1'b1; tgt_way = hit_way_r;
          end else if (inv_r) begin
            tgt_ok = 1'b1; tgt_way = inv_way_r;
          end else if (exp_r) begin
            tgt_ok = 1'b1; tgt_way = exp_way_r;
          end else begin
            tgt_ok = 1'b0;
          end
          if (tgt_ok) begin
            mem_we                 = 1'b1;
            mem_wr_addr            = {it_set, tgt_way};
            mem_wdata.port         = it_port;
            mem_wdata.server_ip    = it_sip;
            mem_wdata.server_port  = it_sport;
            mem_wdata.cli_addr     = it_cip;
            mem_wdata.if_index     = it_if;
            mem_wdata.sub_if_index = it_sub;
            mem_wdata.stamp        = it_now;
            if (func_r == FN_FORWARD) mem_wdata.txid = it_txid;
            else if (hit_r)           mem_wdata.txid = hit_row_r.txid;
            else                      mem_wdata.txid = '0;
            // age out other expired ways on a request
            if (func_r == FN_REQUEST) begin
              for (int i = 0; i < WAYS; i++) begin
                if (expv_r[i] && (WAY_W'(i) != tgt_way))
                  valid_nxt[{it_set, WAY_W'(i)}] = 1'b0;
              end
            end
            valid_nxt[mem_wr_addr] = 1'b1;
            res_status_nxt = ST_OK;
            res_data_nxt   = {112'd0, redirect_port_r, redirect_ip_r};
          end else begin
            res_status_nxt = ST_NOROOM;
          end
        end
      end

      // walk the whole store for the newest txid match
      FSM_SCAN: begin
        if (cnt_r < CNT_W'(NWAY)) begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = cnt_r[ADDR_W-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = mem_rd_addr;
          cnt_nxt      = cnt_r + 1'b1;
        end
        if (pend_r && pend_valid && (mem_q_r.txid == it_txid) &&
            (mem_q_r.stamp > best_r)) begin
          best_nxt    = mem_q_r.stamp;
          hit_nxt     = 1'b1;
          hit_row_nxt = mem_q_r;
        end
        if (scan_last) begin
          if (hit_nxt) begin
            res_status_nxt = ST_OK;
            res_data_nxt   = {hit_row_nxt.sub_if_index, hit_row_nxt.if_index,
                              hit_row_nxt.port, hit_row_nxt.cli_addr,
                              hit_row_nxt.server_port, hit_row_nxt.server_ip};
          end else begin
            res_status_nxt = ST_NOTFOUND;
            res_data_nxt   = '0;
          end
        end
      end

      FSM_DONE: ;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FSM_IDLE;
      pend_r       <= 1'b0;
      valid_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
      if (load_out)        out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_tdata;
      func_r <= func_t'(in_tuser);
    end
    cnt_r        <= cnt_nxt;
    pend_idx_r   <= pend_idx_nxt;
    hit_r        <= hit_nxt;
    hit_way_r    <= hit_way_nxt;
    hit_row_r    <= hit_row_nxt;
    inv_r        <= inv_nxt;
    inv_way_r    <= inv_way_nxt;
    exp_r        <= exp_nxt;
    exp_way_r    <= exp_way_nxt;
    expv_r       <= expv_nxt;
    best_r       <= best_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    if (load_out) begin
      out_tdata_r  <= res_data_r;
      out_status_r <= res_status_r;
    end
  end

  // outputs
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_status_r;

endmodule
